// ===== hdl/tfb_pkg.sv =====
// Package: frame constants, controller state type and control/status structs.
`default_nettype none
package tfb_pkg;

  localparam int LongLen  = 26;
  localparam int ShortLen = 6;
  localparam int IdxW     = 5;
  localparam int SumPos   = 24;

  localparam logic [7:0] LongHdr0  = 8'hAA;
  localparam logic [7:0] LongHdr1  = 8'hFF;
  localparam logic [7:0] LongHdr2  = 8'hF1;
  localparam logic [7:0] LongHdr3  = 8'h14;
  localparam logic [7:0] ShortHdr0 = 8'h55;
  localparam logic [7:0] ShortHdr1 = 8'h53;

  localparam logic [IdxW-1:0] LongLastIdx  = IdxW'(LongLen - 1);
  localparam logic [IdxW-1:0] ShortLastIdx = IdxW'(ShortLen - 1);
  localparam logic [IdxW-1:0] SumIdx       = IdxW'(SumPos);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } tfb_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } tfb_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_pos;
  } tfb_status_t;

endpackage
`default_nettype wire

// ===== hdl/tfb_ctrl.sv =====
// Controller: frame sequencing state machine and input handshake.
`default_nettype none
module tfb_ctrl
  import tfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire tfb_status_t status,
  output tfb_cmd_t         cmd
);

  tfb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.emit = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SEND: begin
        cmd.emit = status.out_free;
        // next set may enter as the last byte of this frame is sent
        in_stall = !(status.out_free && status.last_pos);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    cmd.load = in_valid && !in_stall;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (cmd.emit && status.last_pos) state_nxt = cmd.load ? ST_SEND : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/tfb_datapath.sv =====
// Datapath: value capture, byte select, check sums and output register.
`default_nettype none
module tfb_datapath
  import tfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [0:0]         cfg_wr_data,
  input  wire logic signed [31:0] in_value_one,
  input  wire logic signed [15:0] in_value_two,
  input  wire logic signed [15:0] in_value_three,
  input  wire logic signed [15:0] in_value_four,
  input  wire logic signed [31:0] in_value_five,
  input  wire logic signed [31:0] in_value_six,
  input  wire logic signed [15:0] in_value_seven,
  input  wire logic signed [15:0] in_value_eight,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_frame_byte,
  output logic                    out_last_byte,
  input  wire tfb_cmd_t           cmd,
  output tfb_status_t             status
);

  logic            short_frame_r;
  logic            mode_r;
  logic [31:0]     v1_r, v5_r, v6_r;
  logic [15:0]     v2_r, v3_r, v4_r, v7_r, v8_r;
  logic [IdxW-1:0] idx_r;
  logic [7:0]      sum_r, acc_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic [7:0]      cur_byte;
  logic [7:0]      sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_frame_r <= 1'b0;
    end else if (cfg_wr_en) begin
      short_frame_r <= cfg_wr_data[0];
    end
  end

  always_comb begin
    cur_byte = 8'h00;
    if (mode_r) begin
      unique case (idx_r)
        5'd0:    cur_byte = ShortHdr0;
        5'd1:    cur_byte = ShortHdr1;
        5'd2:    cur_byte = v1_r[31:24];
        5'd3:    cur_byte = v1_r[23:16];
        5'd4:    cur_byte = v1_r[15:8];
        5'd5:    cur_byte = v1_r[7:0];
        default: cur_byte = 8'h00;
      endcase
    end else begin
      unique case (idx_r)
        5'd0:    cur_byte = LongHdr0;
        5'd1:    cur_byte = LongHdr1;
        5'd2:    cur_byte = LongHdr2;
        5'd3:    cur_byte = LongHdr3;
        5'd4:    cur_byte = v1_r[7:0];
        5'd5:    cur_byte = v1_r[15:8];
        5'd6:    cur_byte = v2_r[7:0];
        5'd7:    cur_byte = v2_r[15:8];
        5'd8:    cur_byte = v3_r[7:0];
        5'd9:    cur_byte = v3_r[15:8];
        5'd10:   cur_byte = v4_r[7:0];
        5'd11:   cur_byte = v4_r[15:8];
        5'd12:   cur_byte = v5_r[7:0];
        5'd13:   cur_byte = v5_r[15:8];
        5'd14:   cur_byte = v5_r[23:16];
        5'd15:   cur_byte = v5_r[31:24];
        5'd16:   cur_byte = v6_r[7:0];
        5'd17:   cur_byte = v6_r[15:8];
        5'd18:   cur_byte = v6_r[23:16];
        5'd19:   cur_byte = v6_r[31:24];
        5'd20:   cur_byte = v7_r[7:0];
        5'd21:   cur_byte = v7_r[15:8];
        5'd22:   cur_byte = v8_r[7:0];
        5'd23:   cur_byte = v8_r[15:8];
        5'd24:   cur_byte = sum_r;
        5'd25:   cur_byte = acc_r;
        default: cur_byte = 8'h00;
      endcase
    end
  end

  assign sum_nxt         = sum_r + cur_byte;
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.last_pos = mode_r ? (idx_r == ShortLastIdx) : (idx_r == LongLastIdx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= short_frame_r;
      v1_r   <= in_value_one;
      v2_r   <= in_value_two;
      v3_r   <= in_value_three;
      v4_r   <= in_value_four;
      v5_r   <= in_value_five;
      v6_r   <= in_value_six;
      v7_r   <= in_value_seven;
      v8_r   <= in_value_eight;
      idx_r  <= '0;
      sum_r  <= 8'h00;
      acc_r  <= 8'h00;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IdxW'(1);
      // check sums cover header and payload only
      if (idx_r < SumIdx) begin
        sum_r <= sum_nxt;
        acc_r <= acc_r + sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= status.last_pos;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/telemetry_frame_builder.sv =====
// Top level: telemetry byte frame builder.
// Usage:
//   Input channel (in_valid/in_stall) takes one transfer of eight values.
//   Output channel (out_valid/out_stall) gives one frame byte per transfer,
//   with out_last_byte set on the final byte of the frame.
//   cfg_wr_en/cfg_wr_data write short_frame (0: 26-byte checksummed frame,
//   1: 6-byte frame); write only while no frame is in progress. The mode is
//   sampled when a set of values is taken.
// First byte: loaded from the registered values once the output register is free.
// Throughput: one byte per cycle while out_stall is low, from the byte counter
//   and output register; the next set of values is taken in the cycle the last
//   byte is loaded, giving back-to-back frames.
// Reset: rst_n (synchronous, active low) clears short_frame to 0, drops any
//   frame in progress and empties the output register.
// Stall: while out_stall holds a byte, the byte counter waits and, during a
//   frame, the input stays stalled; no byte is lost or repeated.
`default_nettype none
module telemetry_frame_builder
  import tfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [0:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_value_one,
  input  wire logic signed [15:0] in_value_two,
  input  wire logic signed [15:0] in_value_three,
  input  wire logic signed [15:0] in_value_four,
  input  wire logic signed [31:0] in_value_five,
  input  wire logic signed [31:0] in_value_six,
  input  wire logic signed [15:0] in_value_seven,
  input  wire logic signed [15:0] in_value_eight,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_frame_byte,
  output logic                    out_last_byte
);

  tfb_cmd_t    cmd;
  tfb_status_t status;

  tfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tfb_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_value_one   (in_value_one),
    .in_value_two   (in_value_two),
    .in_value_three (in_value_three),
    .in_value_four  (in_value_four),
    .in_value_five  (in_value_five),
    .in_value_six   (in_value_six),
    .in_value_seven (in_value_seven),
    .in_value_eight (in_value_eight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
`default_nettype wire
